// ----- rtl/rgb_nearest_centroid_classifier_defines.svh -----
// Assertion helpers for the color classifier.
// Each macro expects clk_i and rst_ni in scope.
`ifndef RGB_NEAREST_CENTROID_CLASSIFIER_DEFINES_SVH
`define RGB_NEAREST_CENTROID_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define RNC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RNC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rgbnc_pkg.sv -----
package rgbnc_pkg;

  localparam int unsigned MEAN_W        = 19;
  localparam int unsigned TABLE_CLASSES = 7;
  localparam int unsigned NUM_CH        = 3;
  localparam int unsigned NUM_SETS      = 2;
  localparam int unsigned CODE_W        = 3;

  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;

  typedef logic [MEAN_W-1:0] mean_t;

  // Class means in hundredths of a count: [set][class][r,g,b].
  localparam mean_t CLASS_MEANS [NUM_SETS][TABLE_CLASSES][NUM_CH] = '{
    '{
      '{19'd232568, 19'd192509, 19'd158123},
      '{19'd208795, 19'd311386, 19'd176526},
      '{19'd195546, 19'd267910, 19'd250258},
      '{19'd459568, 19'd442656, 19'd217692},
      '{19'd426413, 19'd276862, 19'd185692},
      '{19'd152664, 19'd170161, 19'd143649},
      '{19'd292818, 19'd345341, 19'd273457}
    },
    '{
      '{19'd185682, 19'd166125, 19'd141812},
      '{19'd162012, 19'd234742, 19'd153525},
      '{19'd136742, 19'd205950, 19'd231587},
      '{19'd356262, 19'd344270, 19'd186240},
      '{19'd307677, 19'd192745, 19'd151847},
      '{19'd140675, 19'd158702, 19'd131987},
      '{19'd292818, 19'd345341, 19'd273457}
    }
  };

endpackage

// ----- rtl/rgb_nearest_centroid_classifier.sv -----
// Nearest-centroid RGB classifier, seven register stages.
// Throughput: one request per cycle; each stage stalls only when it is full
// and the stage after it cannot take its contents, so bubbles close up.
// Reset (rst_ni low, async): all stage valid bits clear, mean select = 1.
`include "rgb_nearest_centroid_classifier_defines.svh"

module rgb_nearest_centroid_classifier #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned NUM_CLASSES = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write: bit 0 = mean_set_select
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_data_i,
  // sample in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] red_count, [31:16] green_count,
                                      // [47:32] blue_count
  // class out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [2:0] class_code, [7:3] zero
);
  import rgbnc_pkg::*;

  // Datapath widths. Counts are scaled by 100 (< 2^7).
  localparam int unsigned SCALED_W = SAMPLE_BITS + 7;
  localparam int unsigned DIFF_W   = (SCALED_W > MEAN_W) ? SCALED_W : MEAN_W;
  localparam int unsigned SQ_W     = 2 * DIFF_W;
  localparam int unsigned DIST_W   = SQ_W + 2;

  // Stages: 0 scale, 1 abs diff, 2 square, 3 sum (leaves),
  //         4 tree level 1, 5 tree level 2, 6 output register.
  localparam int unsigned NSTG = 7;
  localparam int unsigned ST_SCALE = 0;
  localparam int unsigned ST_DIFF  = 1;
  localparam int unsigned ST_SQ    = 2;
  localparam int unsigned ST_SUM   = 3;
  localparam int unsigned ST_L1    = 4;
  localparam int unsigned ST_L2    = 5;
  localparam int unsigned ST_OUT   = 6;

  typedef struct packed {
    logic              vld;   // class takes part
    logic              tie;   // minimum shared by two or more classes
    logic [CODE_W-1:0] code;
    logic [DIST_W-1:0] sq_sum;
  } node_t;

  // Pick the smaller distance; equal distances mark a tie.
  function automatic node_t pick(node_t a, node_t b);
    node_t r;
    if (!b.vld) begin
      r = a;
    end else if (!a.vld) begin
      r = b;
    end else if (a.sq_sum < b.sq_sum) begin
      r = a;
    end else if (b.sq_sum < a.sq_sum) begin
      r = b;
    end else begin
      r     = a;
      r.tie = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic mean_sel_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_sel_q <= 1'b1;
    end else if (cfg_valid_i) begin
      mean_sel_q <= cfg_data_i[0];
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: a stage advances when empty or its successor moves.
  // ---------------------------------------------------------------------
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !v_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];

  // ---------------------------------------------------------------------
  // Stage 0: mask to SAMPLE_BITS and scale by 100 (x<<6 + x<<5 + x<<2)
  // ---------------------------------------------------------------------
  logic [SCALED_W-1:0] scaled_d [NUM_CH];
  logic [SCALED_W-1:0] scaled_q [NUM_CH];
  logic                set_q;

  always_comb begin
    logic [SCALED_W-1:0] x;
    for (int c = 0; c < NUM_CH; c++) begin
      x = SCALED_W'(s_axis_tdata[16*c +: SAMPLE_BITS]);
      scaled_d[c] = (x << 6) + (x << 5) + (x << 2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_SCALE]) begin
      scaled_q <= scaled_d;
      set_q    <= mean_sel_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: absolute difference to every class mean
  // ---------------------------------------------------------------------
  logic [DIFF_W-1:0] diff_d [TABLE_CLASSES][NUM_CH];
  logic [DIFF_W-1:0] diff_q [TABLE_CLASSES][NUM_CH];

  always_comb begin
    logic [DIFF_W-1:0] a;
    logic [DIFF_W-1:0] m;
    for (int k = 0; k < TABLE_CLASSES; k++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        a = DIFF_W'(scaled_q[c]);
        m = DIFF_W'(CLASS_MEANS[set_q][k][c]);
        diff_d[k][c] = (a > m) ? (a - m) : (m - a);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_DIFF]) begin
      diff_q <= diff_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: squares
  // ---------------------------------------------------------------------
  logic [SQ_W-1:0] sq_d [TABLE_CLASSES][NUM_CH];
  logic [SQ_W-1:0] sq_q [TABLE_CLASSES][NUM_CH];

  always_comb begin
    for (int k = 0; k < TABLE_CLASSES; k++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        sq_d[k][c] = SQ_W'(diff_q[k][c]) * SQ_W'(diff_q[k][c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_SQ]) begin
      sq_q <= sq_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: per-class distance, tree leaves
  // ---------------------------------------------------------------------
  node_t leaf_d [TABLE_CLASSES];
  node_t leaf_q [TABLE_CLASSES];

  always_comb begin
    for (int k = 0; k < TABLE_CLASSES; k++) begin
      leaf_d[k].vld    = (k < NUM_CLASSES);
      leaf_d[k].tie    = 1'b0;
      leaf_d[k].code   = CODE_W'(k + 1);
      leaf_d[k].sq_sum = DIST_W'(sq_q[k][CH_RED]) + DIST_W'(sq_q[k][CH_GREEN])
                       + DIST_W'(sq_q[k][CH_BLUE]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_SUM]) begin
      leaf_q <= leaf_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 4..5: minimum tree, 7 -> 4 -> 2
  // ---------------------------------------------------------------------
  node_t l1_d [4];
  node_t l1_q [4];
  node_t l2_d [2];
  node_t l2_q [2];
  node_t idle_node;
  node_t root;

  assign idle_node = '0;

  assign l1_d[0] = pick(leaf_q[0], leaf_q[1]);
  assign l1_d[1] = pick(leaf_q[2], leaf_q[3]);
  assign l1_d[2] = pick(leaf_q[4], leaf_q[5]);
  assign l1_d[3] = pick(leaf_q[6], idle_node);

  always_ff @(posedge clk_i) begin
    if (adv[ST_L1]) begin
      l1_q <= l1_d;
    end
  end

  assign l2_d[0] = pick(l1_q[0], l1_q[1]);
  assign l2_d[1] = pick(l1_q[2], l1_q[3]);

  always_ff @(posedge clk_i) begin
    if (adv[ST_L2]) begin
      l2_q <= l2_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: final compare into the output register
  // ---------------------------------------------------------------------
  logic [CODE_W-1:0] code_q;

  assign root = pick(l2_q[0], l2_q[1]);

  always_ff @(posedge clk_i) begin
    if (adv[ST_OUT]) begin
      code_q <= root.tie ? CODE_NONE : root.code;
    end
  end

  assign m_axis_tvalid = v_q[ST_OUT];
  assign m_axis_tdata  = {{(8 - CODE_W){1'b0}}, code_q};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `RNC_ASSERT_NXT(a_accept_fills, s_axis_tvalid && s_axis_tready, v_q[ST_SCALE],
                  "accepted request did not reach stage 0")
  `RNC_ASSERT_IMP(a_code_range, m_axis_tvalid, m_axis_tdata[2:0] <= NUM_CLASSES,
                  "class code beyond configured class count")
  `RNC_ASSERT_NXT(a_tie_none, v_q[ST_L2] && adv[ST_OUT] && root.tie,
                  m_axis_tdata[2:0] == CODE_NONE, "tie did not give code none")
  `RNC_ASSERT_NXT(a_l1_hold, v_q[ST_L1] && !adv[ST_L1],
                  v_q[ST_L1] && $stable(l1_q[0].sq_sum), "stalled tree stage changed")

endmodule

// ----- sim/tb_rgb_nearest_centroid_classifier.sv -----
module tb_rgb_nearest_centroid_classifier;
  import rgbnc_pkg::*;

  typedef enum logic [CODE_W-1:0] {
    CLS_NONE = CODE_NONE,
    CLS_RED,
    CLS_GREEN,
    CLS_BLUE,
    CLS_YELLOW,
    CLS_ORANGE,
    CLS_PURPLE_BROWN,
    CLS_EMPTY
  } cls_e;

  localparam logic MEAN_SET_A = 1'b0;
  localparam logic MEAN_SET_B = 1'b1;
  localparam int unsigned CLASSES = 7;
  localparam int unsigned PHASE_ITEMS = 240;
  localparam int unsigned DRAIN_CYCLES = 12;

  // Class centroids in hundredths of a count: [set][class][r,g,b].
  localparam int unsigned HUE_MEANS [2][CLASSES][3] = '{
    '{
      '{232568, 192509, 158123},
      '{208795, 311386, 176526},
      '{195546, 267910, 250258},
      '{459568, 442656, 217692},
      '{426413, 276862, 185692},
      '{152664, 170161, 143649},
      '{292818, 345341, 273457}
    },
    '{
      '{185682, 166125, 141812},
      '{162012, 234742, 153525},
      '{136742, 205950, 231587},
      '{356262, 344270, 186240},
      '{307677, 192745, 151847},
      '{140675, 158702, 131987},
      '{292818, 345341, 273457}
    }
  };

  typedef struct {
    bit          is_cfg;
    logic        set_val;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    bit          has_code;
    cls_e        code;
  } plan_row_t;

  // Directed part: extremes, a sample on every centroid of both sets.
  localparam int unsigned PLAN_ROWS = 22;
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{1'b0, MEAN_SET_B, 16'h0000, 16'h0000, 16'h0000, 1'b0, CLS_NONE},
    '{1'b0, MEAN_SET_B, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, CLS_NONE},
    '{1'b0, MEAN_SET_B, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, CLS_NONE},
    '{1'b0, MEAN_SET_B, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, CLS_NONE},
    '{1'b0, MEAN_SET_B, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, CLS_NONE},
    '{1'b0, MEAN_SET_B, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, CLS_NONE},
    '{1'b0, MEAN_SET_B, 16'd1857, 16'd1661, 16'd1418, 1'b1, CLS_RED},
    '{1'b0, MEAN_SET_B, 16'd1620, 16'd2347, 16'd1535, 1'b1, CLS_GREEN},
    '{1'b0, MEAN_SET_B, 16'd1367, 16'd2060, 16'd2316, 1'b1, CLS_BLUE},
    '{1'b0, MEAN_SET_B, 16'd3563, 16'd3443, 16'd1862, 1'b1, CLS_YELLOW},
    '{1'b0, MEAN_SET_B, 16'd3077, 16'd1927, 16'd1518, 1'b1, CLS_ORANGE},
    '{1'b0, MEAN_SET_B, 16'd1407, 16'd1587, 16'd1320, 1'b1, CLS_PURPLE_BROWN},
    '{1'b0, MEAN_SET_B, 16'd2928, 16'd3453, 16'd2735, 1'b1, CLS_EMPTY},
    '{1'b1, MEAN_SET_A, 16'h0000, 16'h0000, 16'h0000, 1'b0, CLS_NONE},
    '{1'b0, MEAN_SET_A, 16'd2326, 16'd1925, 16'd1581, 1'b1, CLS_RED},
    '{1'b0, MEAN_SET_A, 16'd2088, 16'd3114, 16'd1765, 1'b1, CLS_GREEN},
    '{1'b0, MEAN_SET_A, 16'd1955, 16'd2679, 16'd2503, 1'b1, CLS_BLUE},
    '{1'b0, MEAN_SET_A, 16'd4596, 16'd4427, 16'd2177, 1'b1, CLS_YELLOW},
    '{1'b0, MEAN_SET_A, 16'd4264, 16'd2769, 16'd1857, 1'b1, CLS_ORANGE},
    '{1'b0, MEAN_SET_A, 16'd1527, 16'd1702, 16'd1436, 1'b1, CLS_PURPLE_BROWN},
    '{1'b0, MEAN_SET_A, 16'd2928, 16'd3453, 16'd2735, 1'b1, CLS_EMPTY},
    '{1'b0, MEAN_SET_A, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, CLS_NONE}
  };

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_data_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [15:0] red, [31:16] green, [47:32] blue
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [2:0] class_code, [7:3] zero

  // Expected class codes, oldest first, and the mean set the block holds.
  cls_e        class_due [$];
  logic        active_set = MEAN_SET_B;
  logic        drive_set = MEAN_SET_B;
  int unsigned mismatches = 0;

  // Typed-in expectation riding along with the current request.
  bit          due_known = 1'b0;
  cls_e        due_code = CLS_NONE;

  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;

  rgb_nearest_centroid_classifier dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Squared distance to every centroid; a unique minimum wins, else none.
  function automatic cls_e nearest_class(input logic [15:0] r, g, b, input logic set);
    longint unsigned px [3];
    longint unsigned d;
    longint unsigned span;
    longint unsigned best = 0;
    int unsigned     best_k = 0;
    int unsigned     winners = 0;
    px[0] = longint'(r) * 100;
    px[1] = longint'(g) * 100;
    px[2] = longint'(b) * 100;
    for (int k = 0; k < CLASSES; k++) begin
      span = 0;
      for (int c = 0; c < 3; c++) begin
        d = (HUE_MEANS[set][k][c] > px[c]) ? HUE_MEANS[set][k][c] - px[c]
                                           : px[c] - HUE_MEANS[set][k][c];
        span += d * d;
      end
      if (k == 0 || span < best) begin
        best = span;
        best_k = k + 1;
        winners = 1;
      end else if (span == best) begin
        winners++;
      end
    end
    return (winners == 1) ? cls_e'(best_k) : CLS_NONE;
  endfunction

  function automatic int unsigned idle_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic offer_sample(input logic [15:0] r, g, b, input bit has_code,
                              input cls_e code);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) send_steady = !send_steady;
    gap = idle_gap(send_steady);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    due_known     <= has_code;
    due_code      <= code;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Mean set changes only with the pipeline empty. It first drops tvalid and waits on
  // the clock, so the request accepted at the previous edge is already in the queue.
  task automatic load_mean_set(input logic v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (class_due.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    drive_set = v;
  endtask

  // Points on the bisector plane of two centroids: 200*(mj-mi).x = |mj|^2-|mi|^2.
  // Solve for blue around the midpoint; keep the ones where the tie is the minimum.
  task automatic probe_ties(input logic set);
    longint ar, ag, ab, rhs, num, rr, gg, bb;
    int     found;
    for (int i = 0; i < CLASSES; i++) begin
      for (int j = i + 1; j < CLASSES; j++) begin
        ar = 200 * (longint'(HUE_MEANS[set][j][0]) - longint'(HUE_MEANS[set][i][0]));
        ag = 200 * (longint'(HUE_MEANS[set][j][1]) - longint'(HUE_MEANS[set][i][1]));
        ab = 200 * (longint'(HUE_MEANS[set][j][2]) - longint'(HUE_MEANS[set][i][2]));
        rhs = 0;
        for (int c = 0; c < 3; c++)
          rhs += longint'(HUE_MEANS[set][j][c]) * longint'(HUE_MEANS[set][j][c])
               - longint'(HUE_MEANS[set][i][c]) * longint'(HUE_MEANS[set][i][c]);
        found = 0;
        for (int dr = -40; dr <= 40 && ab != 0 && found < 2; dr++) begin
          for (int dg = -40; dg <= 40 && found < 2; dg++) begin
            rr = (longint'(HUE_MEANS[set][i][0]) + HUE_MEANS[set][j][0]) / 200 + dr;
            gg = (longint'(HUE_MEANS[set][i][1]) + HUE_MEANS[set][j][1]) / 200 + dg;
            num = rhs - ar * rr - ag * gg;
            if (num % ab == 0) begin
              bb = num / ab;
              if (rr >= 0 && gg >= 0 && bb >= 0 && bb <= 65535 &&
                  nearest_class(rr[15:0], gg[15:0], bb[15:0], set) == CLS_NONE) begin
                offer_sample(rr[15:0], gg[15:0], bb[15:0], 1'b0, CLS_NONE);
                found++;
              end
            end
          end
        end
      end
    end
  endtask

  // Mostly samples near a centroid or along the line between two of them,
  // the rest spread over the full count range.
  task automatic draw_sample(input logic set, output logic [15:0] r, g, b);
    int unsigned kind, i, j, t;
    int          v [3];
    kind = $urandom_range(0, 9);
    i = $urandom_range(0, CLASSES - 1);
    j = $urandom_range(0, CLASSES - 1);
    t = $urandom_range(0, 100);
    for (int c = 0; c < 3; c++) begin
      if (kind < 5)
        v[c] = int'(HUE_MEANS[set][i][c] / 100) + int'($urandom_range(0, 800)) - 400;
      else if (kind < 8)
        v[c] = int'((HUE_MEANS[set][i][c] * (100 - t) + HUE_MEANS[set][j][c] * t) / 10000)
             + int'($urandom_range(0, 40)) - 20;
      else
        v[c] = int'($urandom_range(0, 65535));
      if (v[c] < 0) v[c] = 0;
      if (v[c] > 65535) v[c] = 65535;
    end
    r = v[0][15:0];
    g = v[1][15:0];
    b = v[2][15:0];
  endtask

  // Result side: random stalls, with stretches of none.
  initial begin
    int unsigned gap;
    forever begin
      if ($urandom_range(0, 29) == 0) recv_steady = !recv_steady;
      gap = idle_gap(recv_steady);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watch both streams and the config channel at each rising edge.
  always @(posedge clk_i) begin : watch
    cls_e want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) active_set = cfg_data_i[0];
      if (s_axis_tvalid && s_axis_tready)
        class_due.push_back(due_known ? due_code
          : nearest_class(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[47:32],
                          active_set));
      if (m_axis_tvalid && m_axis_tready) begin
        if (class_due.size() == 0) begin
          $error("class_code: expected none pending, actual %0d", m_axis_tdata[2:0]);
          mismatches++;
        end else begin
          want = class_due.pop_front();
          if (m_axis_tdata[2:0] !== want) begin
            $error("class_code: expected %0d, actual %0d", want, m_axis_tdata[2:0]);
            mismatches++;
          end
          if (m_axis_tdata[7:3] !== 5'd0) begin
            $error("tdata pad: expected 0, actual %0h", m_axis_tdata[7:3]);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    logic [15:0] r, g, b;
    logic        phase_sets [6] = '{MEAN_SET_A, MEAN_SET_B, MEAN_SET_B,
                                    MEAN_SET_A, MEAN_SET_B, MEAN_SET_A};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[n]) begin
      if (directed_plan[n].is_cfg)
        load_mean_set(directed_plan[n].set_val);
      else
        offer_sample(directed_plan[n].red, directed_plan[n].green, directed_plan[n].blue,
                     directed_plan[n].has_code, directed_plan[n].code);
    end

    // Ties for the minimum, where the count grid admits one.
    probe_ties(MEAN_SET_A);
    load_mean_set(MEAN_SET_B);
    probe_ties(MEAN_SET_B);

    foreach (phase_sets[p]) begin
      load_mean_set(phase_sets[p]);
      repeat (PHASE_ITEMS) begin
        draw_sample(drive_set, r, g, b);
        offer_sample(r, g, b, 1'b0, CLS_NONE);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (class_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #3_600_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- rgb_nearest_centroid_classifier.f -----
+incdir+rtl
rtl/rgbnc_pkg.sv
rtl/rgb_nearest_centroid_classifier.sv
sim/tb_rgb_nearest_centroid_classifier.sv
